// File: sv/spjq_pkg.sv
// Package for the sorted priority job queue.
// Holds the job entry type, item and result codes, and the ordering compare.
// No dependencies.
`timescale 1ns / 1ps

package spjq_pkg;

    typedef struct packed {
        logic [15:0] job_id;
        logic [7:0]  prio;
        logic [15:0] order;
    } t_job;

    typedef enum logic {
        KIND_ENQ = 1'b0,
        KIND_DEQ = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // Shift controls broadcast to every cell in the chain.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctl;

    // True when job a is served before job b.
    function automatic logic goes_before(input t_job a, input t_job b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio > b.prio);
        end else begin
            res = (a.order < b.order);
        end
        return res;
    endfunction

endpackage

// File: sv/spjq_cell.sv
// One slot of the sorted job chain.
// Holds one job; on enqueue keeps, takes the new job or takes its left neighbor,
// on dequeue takes its right neighbor. Depends on spjq_pkg.
`timescale 1ns / 1ps

module spjq_cell (
    input  logic               i_clk,
    input  spjq_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  spjq_pkg::t_job     i_new_job,
    input  spjq_pkg::t_job     i_left_job,
    input  logic               i_left_before,
    input  spjq_pkg::t_job     i_right_job,
    output spjq_pkg::t_job     o_job,
    output logic               o_before
);
    import spjq_pkg::*;

    t_job r_job;

    // New job lands here or further left when this slot is free or loses the compare.
    assign o_before = !i_occupied || goes_before(i_new_job, r_job);
    assign o_job    = r_job;

    always_ff @(posedge i_clk) begin
        if (i_ctl.enq) begin
            if (o_before) begin
                r_job <= i_left_before ? i_left_job : i_new_job;
            end
        end else if (i_ctl.deq) begin
            r_job <= i_right_job;
        end
    end

endmodule

// File: sv/sorted_priority_job_queue.sv
// Sorted priority job queue: a chain of slots kept in service order, head at slot 0.
// Results: an accepted item's result is registered and shows on the outputs in the cycle after it is accepted.
// Throughput: one enqueue or dequeue item per cycle; every slot compares the new job
// and shifts in the same cycle. Input stalls only while a result is held.
// Reset (synchronous, active low) empties the queue and clears the output valid;
// slot contents are left as they are and are never read above the count.
`timescale 1ns / 1ps

module sorted_priority_job_queue #(
    parameter int QUEUE_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [15:0] i_job_id,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_arrival_order,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_job_id,
    output logic [7:0]  o_out_priority,
    output logic [15:0] o_out_order,
    output logic [7:0]  o_occupancy
);
    import spjq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_status       r_status;
    t_status       n_status;
    t_job          r_out_job;
    t_job          n_out_job;

    t_job          w_job    [QUEUE_DEPTH];
    logic          w_before [QUEUE_DEPTH];
    t_job          w_new_job;
    t_cell_ctl     w_ctl;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic [CW+7:0] w_count_ext;

    assign o_stall  = r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_new_job.job_id = i_job_id;
    assign w_new_job.prio   = i_priority_req;
    assign w_new_job.order  = i_arrival_order;

    assign w_ctl.enq = w_accept && (i_kind == KIND_ENQ) && !w_full;
    assign w_ctl.deq = w_accept && (i_kind == KIND_DEQ) && !w_empty;

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_job w_left;
        t_job w_right;
        logic w_lbefore;

        if (gi == 0) begin : g_first
            assign w_left    = w_new_job;
            assign w_lbefore = 1'b0;
        end else begin : g_mid
            assign w_left    = w_job[gi-1];
            assign w_lbefore = w_before[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_right = w_job[gi];
        end else begin : g_inner
            assign w_right = w_job[gi+1];
        end

        spjq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_occupied    (CW'(gi) < r_count),
            .i_new_job     (w_new_job),
            .i_left_job    (w_left),
            .i_left_before (w_lbefore),
            .i_right_job   (w_right),
            .o_job         (w_job[gi]),
            .o_before      (w_before[gi])
        );
    end

    always_comb begin
        n_count   = r_count;
        n_status  = ST_ACCEPTED;
        n_out_job = '0;
        if (i_kind == KIND_ENQ) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_status  = ST_DEQUEUED;
                n_out_job = w_job[0];
                n_count   = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_out_job <= n_out_job;
        end
    end

    assign w_count_ext   = {8'd0, r_count};
    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_out_job_id   = r_out_job.job_id;
    assign o_out_priority = r_out_job.prio;
    assign o_out_order    = r_out_job.order;
    assign o_occupancy    = w_count_ext[7:0];

endmodule
